FILE: rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: shared definitions
// Coordinate width, multiplier chunking, payload types and edge parameter modes.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MUL_CHUNK     = 32;
    localparam int MUL_LAT       = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic signed [COORD_BITS-1:0] query_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic signed [COORD_BITS-1:0] near_z;
    } out_item_t;

    typedef enum logic [1:0] {
        TT_QUOT,
        TT_ZERO,
        TT_COMPL
    } tmode_t;

endpackage

`default_nettype wire

FILE: rtl/cpt_mul.sv
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Sign-magnitude product built from registered chunk partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [AW-1:0]  a,
    input  wire logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0]    p
);

    localparam int CW = cpt_pkg::MUL_CHUNK;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int PWD = AW + BW;

    logic [AW-1:0]     amag;
    logic [BW-1:0]     bmag;
    logic [NA*CW-1:0]  am_reg;
    logic [NB*CW-1:0]  bm_reg;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [2*CW-1:0]   pp_reg [NA][NB];
    logic [PWD-1:0]    sum_next, sum_reg;
    logic signed [PWD-1:0] p_reg;

    assign amag = a[AW-1] ? AW'(-a) : AW'(a);
    assign bmag = b[BW-1] ? BW'(-b) : BW'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            am_reg   <= (NA*CW)'(amag);
            bm_reg   <= (NB*CW)'(bmag);
            neg1_reg <= a[AW-1] ^ b[BW-1];
            neg2_reg <= neg1_reg;
            neg3_reg <= neg2_reg;
            sum_reg  <= sum_next;
            p_reg    <= neg3_reg ? -$signed(sum_reg) : $signed(sum_reg);
        end
    end

    for (genvar i = 0; i < NA; i++) begin : g_row
        for (genvar j = 0; j < NB; j++) begin : g_col
            always_ff @(posedge aclk) begin
                if (en) begin
                    pp_reg[i][j] <= (2*CW)'(am_reg[i*CW +: CW]) * (2*CW)'(bm_reg[j*CW +: CW]);
                end
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                sum_next = sum_next + (PWD'(pp_reg[i][j]) << ((i + j) * CW));
            end
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/cpt_div.sv
// ----------------------------------------------------------------------------
// Pipelined clamped fraction divider
// Returns clamp(num/den, 0, 1) with FB fraction bits, rounded half up; 0 if den <= 0.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_div #(
    parameter int NW = 138,
    parameter int FB = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [NW-1:0] den,
    output logic [FB:0]               quo
);

    localparam int NS = FB + 2;

    logic [NW-1:0] r_reg  [NS];
    logic [NW-1:0] d_reg  [NS];
    logic [FB:0]   q_reg  [NS];
    logic          zf_reg [NS];
    logic          of_reg [NS];
    logic [FB+1:0] rnd;
    logic [FB:0]   quo_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= num;
            d_reg[0]  <= den;
            q_reg[0]  <= '0;
            zf_reg[0] <= (num <= 0) || (den <= 0);
            of_reg[0] <= num >= den;
        end
    end

    for (genvar k = 0; k < NS - 1; k++) begin : g_step
        logic [NW-1:0] rs;
        logic          ge;
        assign rs = {r_reg[k][NW-2:0], 1'b0};
        assign ge = rs >= d_reg[k];
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]  <= ge ? rs - d_reg[k] : rs;
                d_reg[k+1]  <= d_reg[k];
                q_reg[k+1]  <= {q_reg[k][FB-1:0], ge};
                zf_reg[k+1] <= zf_reg[k];
                of_reg[k+1] <= of_reg[k];
            end
        end
    end

    assign rnd = (FB+2)'(q_reg[NS-1]) + (FB+2)'(1);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zf_reg[NS-1]) begin
                quo_reg <= '0;
            end else if (of_reg[NS-1]) begin
                quo_reg <= (FB+1)'(1) << FB;
            end else begin
                quo_reg <= rnd[FB+1:1];
            end
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/cpt_delay.sv
// ----------------------------------------------------------------------------
// Side data delay line
// Holds per-item data alongside a fixed-latency arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic [W-1:0]      q
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/closest_point_on_triangle_core.sv
// ----------------------------------------------------------------------------
// Closest point on triangle core
// Nearest point of a 3D triangle to a query point, exact fixed-point math.
// ----------------------------------------------------------------------------
// The s_ channel carries one triangle and query point per transfer, the m_
// channel one nearest point per transfer, both with valid/ready handshakes.
// The block is a single pipeline of 3*MUL_LAT + FRAC_BITS + 11 stages from
// input transfer to output valid. A new transfer is taken every cycle while
// the output is not stalled; the rate is set by the fully pipelined
// multipliers and the one-bit-per-stage fraction dividers.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all stage valid bits; no result is
// pending afterwards. Triangles with a repeated vertex are resolved on a segment, and
// results saturate to the signed coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_triangle_core #(
    parameter int FRAC_BITS = cpt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cpt_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cpt_pkg::out_item_t       m_data
);

    localparam int CB    = cpt_pkg::COORD_BITS;
    localparam int FB    = FRAC_BITS;
    localparam int ML    = cpt_pkg::MUL_LAT;
    localparam int D     = CB + 1;
    localparam int PW    = 2 * D;
    localparam int P     = PW + 2;
    localparam int BWD   = 2 * P;
    localparam int W     = BWD + 1;
    localparam int DLAT  = FB + 3;
    localparam int EW    = FB + 2;
    localparam int EP    = D + EW;
    localparam int TOTAL = 8 + 3 * ML + DLAT;
    localparam int IA = 0, IB = 1, IC = 2, ID = 3, IE = 4;
    localparam int SW1 = 1 + 3 * CB + 6 * D;
    localparam int SW2 = SW1 + 5 * P;
    localparam int SW3 = 2 + 3 * CB + 6 * D;

    localparam int M2A [6] = '{IA, IB, IB, IC, IB, IA};
    localparam int M2B [6] = '{IC, IB, IE, ID, ID, IE};

    logic                adv;
    logic [TOTAL-1:0]    vld_reg, vld_next;
    cpt_pkg::in_item_t   in_reg;
    cpt_pkg::out_item_t  out_reg, out_next;

    assign adv      = !vld_reg[TOTAL-1] || m_ready;
    assign vld_next = {vld_reg[TOTAL-2:0], s_valid};
    assign s_ready  = adv;
    assign m_valid  = vld_reg[TOTAL-1];
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Stage 2: edge and offset vectors.
    logic [2:0][CB-1:0] av, bv, cv, qv;
    logic [2:0][CB-1:0] va_reg, vb_reg, vc_reg;
    logic [2:0][D-1:0]  e0_reg, e1_reg, e2_reg, w_reg, qb_reg, qc_reg;

    always_comb begin
        av = {in_reg.a_z, in_reg.a_y, in_reg.a_x};
        bv = {in_reg.b_z, in_reg.b_y, in_reg.b_x};
        cv = {in_reg.c_z, in_reg.c_y, in_reg.c_x};
        qv = {in_reg.query_z, in_reg.query_y, in_reg.query_x};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= s_data;
            va_reg <= av;
            vb_reg <= bv;
            vc_reg <= cv;
            for (int k = 0; k < 3; k++) begin
                e0_reg[k] <= D'($signed(bv[k])) - D'($signed(av[k]));
                e1_reg[k] <= D'($signed(cv[k])) - D'($signed(av[k]));
                e2_reg[k] <= D'($signed(bv[k])) - D'($signed(cv[k]));
                w_reg[k]  <= D'($signed(av[k])) - D'($signed(qv[k]));
                qb_reg[k] <= D'($signed(qv[k])) - D'($signed(bv[k]));
                qc_reg[k] <= D'($signed(qv[k])) - D'($signed(cv[k]));
            end
        end
    end

    // Stage 3: degenerate cases and dot product operands.
    logic               z0, z1, z2, seg;
    logic [2:0][D-1:0]  edge_v, rel_v, ee0_n, ee1_n;
    logic [2:0][CB-1:0] base_n;
    logic [4:0][2:0][D-1:0] opa_n, opb_n, opa_reg, opb_reg;
    logic [SW1-1:0]     side1_reg, side1_q;

    assign z0  = e0_reg == '0;
    assign z1  = e1_reg == '0;
    assign z2  = e2_reg == '0;
    assign seg = z0 || z1 || z2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (z0) begin
                edge_v[k] = e2_reg[k];
                rel_v[k]  = qc_reg[k];
            end else if (z1) begin
                edge_v[k] = -e0_reg[k];
                rel_v[k]  = qb_reg[k];
            end else begin
                edge_v[k] = -e1_reg[k];
                rel_v[k]  = qc_reg[k];
            end
        end
        base_n = z1 ? vb_reg : (z0 || z2) ? vc_reg : va_reg;
        ee0_n  = seg ? edge_v : e0_reg;
        ee1_n  = seg ? edge_v : e1_reg;
        opa_n[IA] = seg ? edge_v : e0_reg;
        opb_n[IA] = seg ? edge_v : e0_reg;
        opa_n[IB] = e0_reg;
        opb_n[IB] = e1_reg;
        opa_n[IC] = e1_reg;
        opb_n[IC] = e1_reg;
        opa_n[ID] = seg ? edge_v : e0_reg;
        opb_n[ID] = seg ? rel_v : w_reg;
        opa_n[IE] = e1_reg;
        opb_n[IE] = w_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            opa_reg   <= opa_n;
            opb_reg   <= opb_n;
            side1_reg <= {seg, base_n, ee0_n, ee1_n};
        end
    end

    logic signed [PW-1:0] prod1 [5][3];

    for (genvar k = 0; k < 5; k++) begin : g_dot
        for (genvar j = 0; j < 3; j++) begin : g_comp
            cpt_mul #(.AW(D), .BW(D)) u_mul (
                .aclk (aclk),
                .en   (adv),
                .a    ($signed(opa_reg[k][j])),
                .b    ($signed(opb_reg[k][j])),
                .p    (prod1[k][j])
            );
        end
    end

    cpt_delay #(.W(SW1), .DEPTH(ML)) u_dly1 (
        .aclk (aclk),
        .en   (adv),
        .d    (side1_reg),
        .q    (side1_q)
    );

    // Stage 4: dot products.
    logic [4:0][P-1:0] dot_reg;
    logic [SW1-1:0]    side4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 5; k++) begin
                dot_reg[k] <= P'(prod1[k][0]) + P'(prod1[k][1]) + P'(prod1[k][2]);
            end
            side4_reg <= side1_q;
        end
    end

    logic signed [BWD-1:0] prod2 [6];
    logic [SW2-1:0]        side2_q;

    for (genvar m = 0; m < 6; m++) begin : g_big
        cpt_mul #(.AW(P), .BW(P)) u_mul (
            .aclk (aclk),
            .en   (adv),
            .a    ($signed(dot_reg[M2A[m]])),
            .b    ($signed(dot_reg[M2B[m]])),
            .p    (prod2[m])
        );
    end

    cpt_delay #(.W(SW2), .DEPTH(ML)) u_dly2 (
        .aclk (aclk),
        .en   (adv),
        .d    ({side4_reg, dot_reg}),
        .q    (side2_q)
    );

    // Stage 6: determinant, barycentric numerators, edge terms.
    logic [4:0][P-1:0]        dots_d;
    logic [SW1-1:0]           side6_n;
    logic signed [P:0]        ce, bd, ad, be;
    logic signed [W-1:0]      det_reg, s_reg, t_reg;
    logic signed [P+1:0]      den_reg, en_reg;
    logic signed [P-1:0]      a6_reg, c6_reg, d6_reg, e6_reg;
    logic                     gt1_reg, gt2_reg, seg6_reg;
    logic [2:0][CB-1:0]       base6_reg;
    logic [2:0][D-1:0]        ee06_reg, ee16_reg;

    assign {side6_n, dots_d} = side2_q;
    assign ce = (P+1)'($signed(dots_d[IC])) + (P+1)'($signed(dots_d[IE]));
    assign bd = (P+1)'($signed(dots_d[IB])) + (P+1)'($signed(dots_d[ID]));
    assign ad = (P+1)'($signed(dots_d[IA])) + (P+1)'($signed(dots_d[ID]));
    assign be = (P+1)'($signed(dots_d[IB])) + (P+1)'($signed(dots_d[IE]));

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg <= W'(prod2[0]) - W'(prod2[1]);
            s_reg   <= W'(prod2[2]) - W'(prod2[3]);
            t_reg   <= W'(prod2[4]) - W'(prod2[5]);
            den_reg <= (P+2)'($signed(dots_d[IA])) - ((P+2)'($signed(dots_d[IB])) <<< 1)
                       + (P+2)'($signed(dots_d[IC]));
            en_reg  <= (P+2)'(ce) - (P+2)'(bd);
            gt1_reg <= ce > bd;
            gt2_reg <= ad > be;
            a6_reg  <= dots_d[IA];
            c6_reg  <= dots_d[IC];
            d6_reg  <= dots_d[ID];
            e6_reg  <= dots_d[IE];
            {seg6_reg, base6_reg, ee06_reg, ee16_reg} <= side6_n;
        end
    end

    // Stage 7: region decision and divider operands.
    logic signed [W:0]   st;
    logic                lt;
    logic signed [W-1:0] nd, ne, n1_n, d1_n, n2_n, d2_n;
    logic signed [W-1:0] n1_reg, d1_reg, n2_reg, d2_reg;
    cpt_pkg::tmode_t     mode_n, mode_reg;
    logic [SW3-3:0]      emit7_reg;

    assign st = (W+1)'(s_reg) + (W+1)'(t_reg);
    assign lt = st < (W+1)'(det_reg);
    assign nd = -W'(d6_reg);
    assign ne = -W'(e6_reg);

    always_comb begin
        n1_n   = '0;
        d1_n   = '0;
        n2_n   = '0;
        d2_n   = '0;
        mode_n = cpt_pkg::TT_ZERO;
        if (seg6_reg) begin
            n1_n = W'(d6_reg);
            d1_n = W'(a6_reg);
        end else if (lt) begin
            if (s_reg < 0) begin
                if (t_reg < 0 && d6_reg < 0) begin
                    n1_n = nd;
                    d1_n = W'(a6_reg);
                end else begin
                    n2_n   = ne;
                    d2_n   = W'(c6_reg);
                    mode_n = cpt_pkg::TT_QUOT;
                end
            end else if (t_reg < 0) begin
                n1_n = nd;
                d1_n = W'(a6_reg);
            end else if (det_reg > 0) begin
                n1_n   = s_reg;
                d1_n   = det_reg;
                n2_n   = t_reg;
                d2_n   = det_reg;
                mode_n = cpt_pkg::TT_QUOT;
            end
        end else begin
            if (s_reg < 0 && !gt1_reg) begin
                n2_n   = ne;
                d2_n   = W'(c6_reg);
                mode_n = cpt_pkg::TT_QUOT;
            end else if (s_reg >= 0 && t_reg < 0 && !gt2_reg) begin
                n1_n = nd;
                d1_n = W'(a6_reg);
            end else begin
                n1_n   = W'(en_reg);
                d1_n   = W'(den_reg);
                mode_n = cpt_pkg::TT_COMPL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n1_reg    <= n1_n;
            d1_reg    <= d1_n;
            n2_reg    <= n2_n;
            d2_reg    <= d2_n;
            mode_reg  <= mode_n;
            emit7_reg <= {base6_reg, ee06_reg, ee16_reg};
        end
    end

    logic [FB:0]    q1, q2;
    logic [SW3-1:0] side3_q;

    cpt_div #(.NW(W), .FB(FB)) u_div_s (
        .aclk (aclk),
        .en   (adv),
        .num  (n1_reg),
        .den  (d1_reg),
        .quo  (q1)
    );

    cpt_div #(.NW(W), .FB(FB)) u_div_t (
        .aclk (aclk),
        .en   (adv),
        .num  (n2_reg),
        .den  (d2_reg),
        .quo  (q2)
    );

    cpt_delay #(.W(SW3), .DEPTH(DLAT)) u_dly3 (
        .aclk (aclk),
        .en   (adv),
        .d    ({mode_reg, emit7_reg}),
        .q    (side3_q)
    );

    // Stage 9: clamped parameters.
    cpt_pkg::tmode_t    mode9;
    logic [SW3-3:0]     emit9;
    logic [FB:0]        tt_n, ss_reg, tt_reg;
    logic [2:0][CB-1:0] base9_reg;
    logic [2:0][D-1:0]  ee09_reg, ee19_reg;

    assign mode9 = cpt_pkg::tmode_t'(side3_q[SW3-1:SW3-2]);
    assign emit9 = side3_q[SW3-3:0];

    always_comb begin
        unique case (mode9)
            cpt_pkg::TT_QUOT:  tt_n = q2;
            cpt_pkg::TT_COMPL: tt_n = ((FB+1)'(1) << FB) - q1;
            default:           tt_n = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ss_reg <= q1;
            tt_reg <= tt_n;
            {base9_reg, ee09_reg, ee19_reg} <= emit9;
        end
    end

    logic signed [EP-1:0] ps [3];
    logic signed [EP-1:0] pt [3];
    logic [3*CB-1:0]      base_q;

    for (genvar k = 0; k < 3; k++) begin : g_emit
        cpt_mul #(.AW(D), .BW(EW)) u_mul_s (
            .aclk (aclk),
            .en   (adv),
            .a    ($signed(ee09_reg[k])),
            .b    ($signed({1'b0, ss_reg})),
            .p    (ps[k])
        );
        cpt_mul #(.AW(D), .BW(EW)) u_mul_t (
            .aclk (aclk),
            .en   (adv),
            .a    ($signed(ee19_reg[k])),
            .b    ($signed({1'b0, tt_reg})),
            .p    (pt[k])
        );
    end

    cpt_delay #(.W(3*CB), .DEPTH(ML)) u_dly4 (
        .aclk (aclk),
        .en   (adv),
        .d    (base9_reg),
        .q    (base_q)
    );

    // Output stage: rounding, offset from the base point, saturation.
    logic signed [EP:0]   acc [3];
    logic signed [EP+1:0] vsum [3];
    logic [2:0][CB-1:0]   res;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k]  = (EP+1)'(ps[k]) + (EP+1)'(pt[k]) + ((EP+1)'(1) <<< (FB - 1));
            vsum[k] = (EP+2)'($signed(base_q[k*CB +: CB])) + (EP+2)'(acc[k] >>> FB);
            if (vsum[k][EP+1:CB-1] == '0 || vsum[k][EP+1:CB-1] == '1) begin
                res[k] = vsum[k][CB-1:0];
            end else if (vsum[k][EP+1]) begin
                res[k] = {1'b1, {(CB-1){1'b0}}};
            end else begin
                res[k] = {1'b0, {(CB-1){1'b1}}};
            end
        end
        out_next.near_x = res[0];
        out_next.near_y = res[1];
        out_next.near_z = res[2];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while the output transfer is stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transfer not tracked in the first stage");

endmodule

`default_nettype wire

FILE: tb/tb_closest_point_on_triangle_core.sv
// ----------------------------------------------------------------------------
// Closest point on triangle core testbench
// Drives triangle and query transfers through a directed table and a random
// run under four idle and stall phases. Every result is compared with an
// exact wide-integer prediction of the nearest point or a typed table point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_closest_point_on_triangle_core;

    typedef cpt_pkg::in_item_t  in_item_t;
    typedef cpt_pkg::out_item_t out_item_t;

    typedef logic signed [319:0] wide_t;
    typedef wide_t vec3_t [3];

    localparam int FRAC = cpt_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM = 1100;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t point;
    } table_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    out_item_t nearest_pending[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        quiet_cycles = 0;

    closest_point_on_triangle_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [16:0] frac_quot(wide_t num, wide_t den);
        wide_t       r;
        logic [17:0] q;
        r = num;
        q = '0;
        if (num <= 0 || den <= 0) return 17'd0;
        if (num >= den) return 17'(1 << FRAC);
        for (int i = 0; i <= FRAC; i++) begin
            r = r <<< 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return 17'((q + 1) >> 1);
    endfunction

    function automatic wide_t dot3(vec3_t p, vec3_t q);
        return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function automatic vec3_t diff3(vec3_t p, vec3_t q);
        vec3_t r;
        for (int k = 0; k < 3; k++) r[k] = p[k] - q[k];
        return r;
    endfunction

    function automatic bit is_zero3(vec3_t p);
        return p[0] == 0 && p[1] == 0 && p[2] == 0;
    endfunction

    function automatic out_item_t blend(vec3_t base, vec3_t e0, logic [16:0] s,
                                        vec3_t e1, logic [16:0] t);
        wide_t     acc;
        wide_t     v;
        wide_t     sw;
        wide_t     tw;
        logic [31:0] c [3];
        out_item_t o;
        sw = {303'd0, s};
        tw = {303'd0, t};
        for (int k = 0; k < 3; k++) begin
            acc = e0[k] * sw + e1[k] * tw + (wide_t'(1) <<< (FRAC - 1));
            v = base[k] + (acc >>> FRAC);
            if (v < -(wide_t'(1) <<< 31)) v = -(wide_t'(1) <<< 31);
            if (v > (wide_t'(1) <<< 31) - 1) v = (wide_t'(1) <<< 31) - 1;
            c[k] = v[31:0];
        end
        o.near_x = c[0];
        o.near_y = c[1];
        o.near_z = c[2];
        return o;
    endfunction

    function automatic out_item_t segment_point(vec3_t p0, vec3_t p1, vec3_t q);
        vec3_t       ed;
        logic [16:0] u;
        ed = diff3(p1, p0);
        u = '0;
        if (!is_zero3(ed)) u = frac_quot(dot3(ed, diff3(q, p0)), dot3(ed, ed));
        return blend(p0, ed, u, ed, 17'd0);
    endfunction

    function automatic out_item_t predict_near(in_item_t it);
        vec3_t va, vb, vc, vq, e0, e1, e2, w;
        wide_t a, b, c, d, e, det, s, t, denom, edge_num;
        logic [16:0] ss, tt;
        va[0] = it.a_x; va[1] = it.a_y; va[2] = it.a_z;
        vb[0] = it.b_x; vb[1] = it.b_y; vb[2] = it.b_z;
        vc[0] = it.c_x; vc[1] = it.c_y; vc[2] = it.c_z;
        vq[0] = it.query_x; vq[1] = it.query_y; vq[2] = it.query_z;
        e0 = diff3(vb, va);
        e1 = diff3(vc, va);
        e2 = diff3(vb, vc);
        if (is_zero3(e0)) return segment_point(vc, vb, vq);
        if (is_zero3(e1)) return segment_point(vb, va, vq);
        if (is_zero3(e2)) return segment_point(vc, va, vq);
        w = diff3(va, vq);
        a = dot3(e0, e0);
        b = dot3(e0, e1);
        c = dot3(e1, e1);
        d = dot3(e0, w);
        e = dot3(e1, w);
        det = a * c - b * b;
        s = b * e - c * d;
        t = b * d - a * e;
        denom = a - 2 * b + c;
        edge_num = (c + e) - (b + d);
        if (s + t < det) begin
            if (s < 0) begin
                if (t < 0 && d < 0) begin
                    ss = frac_quot(-d, a); tt = 0;
                end else begin
                    ss = 0; tt = frac_quot(-e, c);
                end
            end else if (t < 0) begin
                ss = frac_quot(-d, a); tt = 0;
            end else if (det > 0) begin
                ss = frac_quot(s, det); tt = frac_quot(t, det);
            end else begin
                ss = 0; tt = 0;
            end
        end else begin
            if (s < 0) begin
                if (c + e > b + d) begin
                    ss = frac_quot(edge_num, denom); tt = 17'(1 << FRAC) - ss;
                end else begin
                    ss = 0; tt = frac_quot(-e, c);
                end
            end else if (t < 0) begin
                if (a + d > b + e) begin
                    ss = frac_quot(edge_num, denom); tt = 17'(1 << FRAC) - ss;
                end else begin
                    ss = frac_quot(-d, a); tt = 0;
                end
            end else begin
                ss = frac_quot(edge_num, denom); tt = 17'(1 << FRAC) - ss;
            end
        end
        return blend(va, e0, ss, e1, tt);
    endfunction

    function automatic in_item_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz, int qx, int qy, int qz);
        in_item_t it;
        it.a_x = ax; it.a_y = ay; it.a_z = az;
        it.b_x = bx; it.b_y = by; it.b_z = bz;
        it.c_x = cx; it.c_y = cy; it.c_z = cz;
        it.query_x = qx; it.query_y = qy; it.query_z = qz;
        return it;
    endfunction

    function automatic out_item_t make_pt(int x, int y, int z);
        out_item_t o;
        o.near_x = x; o.near_y = y; o.near_z = z;
        return o;
    endfunction

    function automatic in_item_t random_tri();
        in_item_t it;
        int       kind, span, cx0, cy0, cz0, k;
        kind = $urandom_range(99);
        span = 1 << $urandom_range(4, 22);
        cx0 = $urandom_range(2000000) - 1000000;
        cy0 = $urandom_range(2000000) - 1000000;
        cz0 = $urandom_range(2000000) - 1000000;
        it.a_x = cx0 + $urandom_range(span) - span / 2;
        it.a_y = cy0 + $urandom_range(span) - span / 2;
        it.a_z = cz0 + $urandom_range(span) - span / 2;
        it.b_x = cx0 + $urandom_range(span) - span / 2;
        it.b_y = cy0 + $urandom_range(span) - span / 2;
        it.b_z = cz0 + $urandom_range(span) - span / 2;
        it.c_x = cx0 + $urandom_range(span) - span / 2;
        it.c_y = cy0 + $urandom_range(span) - span / 2;
        it.c_z = cz0 + $urandom_range(span) - span / 2;
        it.query_x = cx0 + $urandom_range(2 * span) - span;
        it.query_y = cy0 + $urandom_range(2 * span) - span;
        it.query_z = cz0 + $urandom_range(2 * span) - span;
        if (kind < 12) begin
            it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end else if (kind < 16) begin
            it.a_x = $urandom; it.b_y = $urandom; it.c_z = $urandom;
            it.query_x = $urandom; it.query_z = $urandom;
        end else if (kind < 20) begin
            {it.b_x, it.b_y, it.b_z} = {it.a_x, it.a_y, it.a_z};
        end else if (kind < 24) begin
            {it.c_x, it.c_y, it.c_z} = {it.a_x, it.a_y, it.a_z};
        end else if (kind < 28) begin
            {it.c_x, it.c_y, it.c_z} = {it.b_x, it.b_y, it.b_z};
        end else if (kind < 30) begin
            {it.b_x, it.b_y, it.b_z} = {it.a_x, it.a_y, it.a_z};
            {it.c_x, it.c_y, it.c_z} = {it.a_x, it.a_y, it.a_z};
        end else if (kind < 35) begin
            k = $urandom_range(5) - 2;
            if (k == 0 || k == 1) k = 3;
            it.b_x = it.a_x + ($urandom_range(200) - 100);
            it.b_y = it.a_y + ($urandom_range(200) - 100);
            it.b_z = it.a_z + ($urandom_range(200) - 100);
            it.c_x = it.a_x + k * (it.b_x - it.a_x);
            it.c_y = it.a_y + k * (it.b_y - it.a_y);
            it.c_z = it.a_z + k * (it.b_z - it.a_z);
        end
        return it;
    endfunction

    task automatic send_tri(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        nearest_pending.insert(nearest_pending.size(), predict_near(it));
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (aresetn) m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (nearest_pending.size() == 0) begin
                $error("unexpected result %h", m_data);
                errors++;
            end else begin
                want = nearest_pending.pop_front();
                if (m_data.near_x !== want.near_x) begin
                    $error("near_x expected %h actual %h", want.near_x, m_data.near_x);
                    errors++;
                end
                if (m_data.near_y !== want.near_y) begin
                    $error("near_y expected %h actual %h", want.near_y, m_data.near_y);
                    errors++;
                end
                if (m_data.near_z !== want.near_z) begin
                    $error("near_z expected %h actual %h", want.near_z, m_data.near_z);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        table_row_t rows[$];
        table_row_t row;
        int         mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        rows.insert(rows.size(), '{make_tri(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(mx,mx,mx, mx,mx,mx, mx,mx,mx, mn,mn,mn), 1,
                                   make_pt(mx,mx,mx)});
        rows.insert(rows.size(), '{make_tri(mn,mn,mn, mn,mn,mn, mn,mn,mn, mx,mx,mx), 1,
                                   make_pt(mn,mn,mn)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, 0,0,0), 1,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(5,6,7, 65536,0,0, 0,65536,0, 5,6,7), 1,
                                   make_pt(5,6,7)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, 16384,16384,99999),
                                   0, make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, -9000,-9000,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, 200000,-5,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, -5,200000,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, 90000,90000,7), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, 100000,30000,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 65536,0,0, 0,65536,0, 30000,100000,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(7,7,7, 7,7,7, 70000,3,-9, 40000,0,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(7,7,7, 70000,3,-9, 7,7,7, 40000,0,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(7,7,7, 70000,3,-9, 70000,3,-9, 40000,0,0), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(0,0,0, 100,100,100, 300,300,300, 150,120,130), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(mx,mn,0, mn,mx,0, mx,mx,mn, mn,mn,mx), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(mn,mn,mn, mx,mn,mn, mn,mx,mn, mx,mx,mx), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(mx,mx,mx, mn,mx,mx, mx,mn,mx, mn,mn,mn), 0,
                                   make_pt(0,0,0)});
        rows.insert(rows.size(), '{make_tri(-1,-1,-1, 1,-1,-1, -1,1,-1, 0,0,-1), 0,
                                   make_pt(0,0,0)});

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            send_tri(row.stim);
            if (row.typed) nearest_pending[nearest_pending.size() - 1] = row.point;
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 4) begin
                send_idle_pct = 83;
                recv_stall_pct = 0;
            end else if (n == N_RANDOM / 2) begin
                s_valid = 1'b0;
                while (nearest_pending.size() != 0) @(negedge aclk);
                send_idle_pct = 0;
                recv_stall_pct = 83;
            end else if (n == 3 * N_RANDOM / 4) begin
                send_idle_pct = 10;
                recv_stall_pct = 10;
            end
            send_tri(random_tri());
        end
        s_valid = 1'b0;
        while (nearest_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && nearest_pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
